### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/brbps_pkg.sv
// ---------------------------------------------------------------------------
// brbps_pkg
// Types and constants for the circular byte buffer with peek and skip.
// ---------------------------------------------------------------------------
package brbps_pkg;

   // Storage size and derived widths
   localparam int DEPTH   = 1024;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int AMT_W   = 11;
   localparam int OFS_W   = 10;

   // Control/status port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_CAPACITY = 1'b0;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   // Request opcodes
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_SKIP  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   // Result fields awaiting the memory read
   typedef struct packed {
      logic             accepted;
      logic [CNT_W-1:0] skipped;
      logic             peek_valid;
      logic [CNT_W-1:0] level;
   } res_type;

endpackage

### rtl/brbps_ram.sv
// ---------------------------------------------------------------------------
// brbps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module brbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/byte_ring_buffer_peek_skip_top.sv
// ---------------------------------------------------------------------------
// byte_ring_buffer_peek_skip_top
// Circular byte buffer of programmable capacity with write, skip, peek and
// level query requests; one result per request.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/ready      opcode, data_byte, amount, offset
//   rsp_      out         rsp_valid/ready      accepted, skipped, peek_byte,
//                                              peek_valid, level
//   csr_      in/out      psel/penable/pready  capacity at byte address 0
//
// One request per cycle while the result side is not stalled; a result
// passes from stage one (position update and memory read) to the result
// register before it appears. The memory read port sets the pipeline depth.
// Reset leaves capacity at 1024 and the buffer empty; no clearing pass.
// A stalled result holds the pipeline; requests keep flowing while the
// result register drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_ring_buffer_peek_skip_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [brbps_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [brbps_pkg::AMT_W-1:0]        req_amount,
   input  logic [brbps_pkg::OFS_W-1:0]        req_offset,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic [brbps_pkg::CNT_W-1:0]        rsp_skipped,
   output logic [brbps_pkg::BYTE_W-1:0]       rsp_peek_byte,
   output logic                               rsp_peek_valid,
   output logic [brbps_pkg::CNT_W-1:0]        rsp_level,
   // control/status port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [brbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [brbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [brbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = brbps_pkg::IDX_W;
   localparam int CNT_W = brbps_pkg::CNT_W;

   // Architectural state
   logic [CNT_W-1:0] cap_ff;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // Pipeline
   logic                     s1_valid_ff;
   brbps_pkg::res_type       s1_res_ff, s1_res_in;
   logic                     rsp_valid_ff;
   brbps_pkg::res_type       rsp_res_ff;
   logic [brbps_pkg::BYTE_W-1:0] rsp_byte_ff;

   logic                     s2_free, s1_adv, req_acc;
   logic                     cfg_reg_sel, cfg_we;
   brbps_pkg::op_type        op;
   logic [CNT_W-1:0]         cap_eff;
   logic [CNT_W-1:0]         wr_inc;
   logic [CNT_W-1:0]         skip_n;
   logic [CNT_W-1:0]         rd_sum, pk_sum;
   logic [IDX_W-1:0]         pk_pos;
   logic                     pk_hit;
   logic                     mem_we, mem_re;
   logic [brbps_pkg::BYTE_W-1:0] mem_rdata;

   // Handshakes
   assign s2_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_acc   = req_valid && req_ready;

   // Register access
   assign cfg_reg_sel = (csr_paddr[brbps_pkg::CSR_ADDR_W-1:2] == brbps_pkg::CSR_CAPACITY);
   assign cfg_we      = csr_psel && csr_penable && csr_pwrite && cfg_reg_sel;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = cfg_reg_sel ? brbps_pkg::CSR_DATA_W'(cap_ff) : '0;

   // Clamp capacity to the usable range
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ff > brbps_pkg::CAP_RESET) begin
         cap_eff = brbps_pkg::CAP_RESET;
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign op = brbps_pkg::op_type'(req_opcode);

   // Position arithmetic: the write and skip sums, and the peek sum on a hit, stay below twice the capacity
   assign wr_inc = CNT_W'(wr_idx_ff) + CNT_W'(1);
   assign skip_n = (req_amount < occ_ff) ? req_amount : occ_ff;
   assign rd_sum = CNT_W'(rd_idx_ff) + skip_n;
   assign pk_sum = CNT_W'(rd_idx_ff) + CNT_W'(req_offset);
   assign pk_hit = CNT_W'(req_offset) < occ_ff;

   always_comb begin
      if (pk_sum >= cap_eff) begin
         pk_pos = IDX_W'(pk_sum - cap_eff);
      end else begin
         pk_pos = IDX_W'(pk_sum);
      end
   end

   // Next state and result fields for the request being taken
   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      occ_in    = occ_ff;
      s1_res_in = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (op)
         brbps_pkg::OP_WRITE: begin
            if (occ_ff < cap_eff) begin
               mem_we    = req_acc;
               wr_idx_in = (wr_inc == cap_eff) ? '0 : IDX_W'(wr_inc);
               occ_in    = occ_ff + CNT_W'(1);
               s1_res_in.accepted = 1'b1;
            end
         end
         brbps_pkg::OP_SKIP: begin
            rd_idx_in = (rd_sum >= cap_eff) ? IDX_W'(rd_sum - cap_eff) : IDX_W'(rd_sum);
            occ_in    = occ_ff - skip_n;
            s1_res_in.skipped = skip_n;
         end
         brbps_pkg::OP_PEEK: begin
            mem_re = req_acc && pk_hit;
            s1_res_in.peek_valid = pk_hit;
         end
         default: begin
         end
      endcase
      s1_res_in.level = occ_in;
   end

   // Hold positions and capacity; a capacity write empties the buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= brbps_pkg::CAP_RESET;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         occ_ff    <= '0;
      end else if (cfg_we) begin
         cap_ff    <= CNT_W'(csr_pwdata);
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         occ_ff    <= '0;
      end else if (req_acc) begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         occ_ff    <= occ_in;
      end
   end

   // Byte store
   brbps_ram #(
      .WIDTH (brbps_pkg::BYTE_W),
      .DEPTH (brbps_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_data_byte),
      .rd_en   (mem_re),
      .rd_addr (pk_pos),
      .rd_data (mem_rdata)
   );

   // Stage one: result fields while the memory read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_res_ff <= s1_res_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_res_ff  <= s1_res_ff;
         rsp_byte_ff <= s1_res_ff.peek_valid ? mem_rdata : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_res_ff.accepted;
   assign rsp_skipped    = rsp_res_ff.skipped;
   assign rsp_peek_byte  = rsp_byte_ff;
   assign rsp_peek_valid = rsp_res_ff.peek_valid;
   assign rsp_level      = rsp_res_ff.level;

   // Checks
   `ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= cap_eff, "occupancy above capacity")
   `ASSERT_IMPL(a_rd_bound, clock, reset, 1'b1, CNT_W'(rd_idx_ff) < cap_eff, "read index out of window")
   `ASSERT_NEXT(a_wr_count, clock, reset,
      req_acc && !cfg_we && op == brbps_pkg::OP_WRITE && occ_ff < cap_eff,
      occ_ff == $past(occ_ff) + CNT_W'(1), "write did not raise occupancy")
   `ASSERT_IMPL(a_rsp_excl, clock, reset, rsp_valid_ff && rsp_res_ff.accepted,
      rsp_res_ff.skipped == '0 && !rsp_res_ff.peek_valid, "write result carries other fields")

endmodule

### tb/byte_ring_buffer_peek_skip_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_ring_buffer_peek_skip_top_tb
// Self-checking bench for the circular byte buffer with peek and skip. A
// behavioural copy of the buffer predicts every result as its request is
// taken. A separate process compares each result, field by field, with the
// oldest prediction while both channels idle and stall at random.
// ---------------------------------------------------------------------------

module byte_ring_buffer_peek_skip_top_tb;

   localparam int CNT_W      = brbps_pkg::CNT_W;
   localparam int BYTE_W     = brbps_pkg::BYTE_W;
   localparam int AMT_W      = brbps_pkg::AMT_W;
   localparam int OFS_W      = brbps_pkg::OFS_W;
   localparam int DEPTH      = brbps_pkg::DEPTH;
   localparam int CSR_ADDR_W = brbps_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = brbps_pkg::CSR_DATA_W;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_GAP     = 20;

   typedef struct {
      logic              accepted;
      logic [CNT_W-1:0]  skipped;
      logic [BYTE_W-1:0] peek_byte;
      logic              peek_valid;
      logic [CNT_W-1:0]  level;
   } buffer_result_type;

   typedef struct {
      brbps_pkg::op_type op;
      logic [BYTE_W-1:0] data;
      logic [AMT_W-1:0]  amount;
      logic [OFS_W-1:0]  offset;
   } buffer_req_type;

   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_opcode;
   logic [BYTE_W-1:0]     req_data_byte;
   logic [AMT_W-1:0]      req_amount;
   logic [OFS_W-1:0]      req_offset;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_accepted;
   logic [CNT_W-1:0]      rsp_skipped;
   logic [BYTE_W-1:0]     rsp_peek_byte;
   logic                  rsp_peek_valid;
   logic [CNT_W-1:0]      rsp_level;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Behavioural copy of the buffer
   logic [BYTE_W-1:0] shadow_bytes [DEPTH];
   logic [CNT_W-1:0]  shadow_capacity;
   int                shadow_rd_pos;
   int                shadow_wr_pos;
   int                shadow_fill;

   buffer_result_type pending_results [$];

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   byte_ring_buffer_peek_skip_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_amount     (req_amount),
      .req_offset     (req_offset),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_skipped    (rsp_skipped),
      .rsp_peek_byte  (rsp_peek_byte),
      .rsp_peek_valid (rsp_peek_valid),
      .rsp_level      (rsp_level),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Work out the result of one request and advance the buffer copy
   function automatic void predict_buffer_op(input buffer_req_type r);
      buffer_result_type res;
      int                cap;
      int                take;
      int                pos;
      res = '{default: '0};
      cap = (shadow_capacity == 0) ? 1 :
            (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
      shadow_rd_pos = shadow_rd_pos % cap;
      shadow_wr_pos = shadow_wr_pos % cap;
      if (shadow_fill > cap) shadow_fill = cap;
      case (r.op)
         brbps_pkg::OP_WRITE: begin
            if (shadow_fill < cap) begin
               shadow_bytes[shadow_wr_pos] = r.data;
               shadow_wr_pos = (shadow_wr_pos + 1) % cap;
               shadow_fill++;
               res.accepted = 1'b1;
            end
         end
         brbps_pkg::OP_SKIP: begin
            take = (int'(r.amount) < shadow_fill) ? int'(r.amount) : shadow_fill;
            shadow_rd_pos = (shadow_rd_pos + take) % cap;
            shadow_fill -= take;
            res.skipped = CNT_W'(take);
         end
         brbps_pkg::OP_PEEK: begin
            if (int'(r.offset) < shadow_fill) begin
               pos = (shadow_rd_pos + int'(r.offset)) % cap;
               res.peek_byte = shadow_bytes[pos];
               res.peek_valid = 1'b1;
            end
         end
         default: ;
      endcase
      res.level = CNT_W'(shadow_fill);
      pending_results.push_back(res);
   endfunction

   // Mostly well-aimed requests: offsets near the fill level, short skips
   function automatic buffer_req_type random_request();
      buffer_req_type r;
      int             pick;
      int             reach;
      pick = $urandom_range(99);
      r.data = BYTE_W'($urandom);
      r.amount = AMT_W'($urandom);
      r.offset = OFS_W'($urandom);
      reach = (shadow_fill + 1 > 1023) ? 1023 : shadow_fill + 1;
      if (pick < 45) begin
         r.op = brbps_pkg::OP_WRITE;
      end else if (pick < 60) begin
         r.op = brbps_pkg::OP_SKIP;
         if ($urandom_range(3) != 0) r.amount = AMT_W'($urandom_range(4));
      end else if (pick < 90) begin
         r.op = brbps_pkg::OP_PEEK;
         if ($urandom_range(3) != 0) r.offset = OFS_W'($urandom_range(reach));
      end else begin
         r.op = brbps_pkg::OP_QUERY;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   // Compare each result with the oldest prediction
   always @(posedge clock) begin : check_results
      buffer_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing expected, level %0d", $time, rsp_level);
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("skipped", 32'(want.skipped), 32'(rsp_skipped));
            check_field("peek_byte", 32'(want.peek_byte), 32'(rsp_peek_byte));
            check_field("peek_valid", 32'(want.peek_valid), 32'(rsp_peek_valid));
            check_field("level", 32'(want.level), 32'(rsp_level));
         end
      end
   end

   // Result side: random stalls, or a long hold when one is asked for
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request and hold it until taken; entered and left at a falling edge
   task automatic send_request(input brbps_pkg::op_type op,
                               input logic [BYTE_W-1:0] data,
                               input logic [AMT_W-1:0] amount,
                               input logic [OFS_W-1:0] offset);
      buffer_req_type r;
      int             gap;
      r = '{op: op, data: data, amount: amount, offset: offset};
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= data;
      req_amount    <= amount;
      req_offset    <= offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_buffer_op(r);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      buffer_req_type r;
      repeat (count) begin
         r = random_request();
         send_request(r.op, r.data, r.amount, r.offset);
      end
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the capacity register with the buffer idle
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * brbps_pkg::CSR_CAPACITY);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      shadow_capacity = value[CNT_W-1:0];
      shadow_rd_pos = 0;
      shadow_wr_pos = 0;
      shadow_fill = 0;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Every opcode on the reset capacity, field extremes in used and unused fields
   task automatic test_directed_ops();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      send_request(brbps_pkg::OP_QUERY, 8'hFF, 11'd2047, 10'd1023);
      send_request(brbps_pkg::OP_PEEK, 8'hFF, 11'd2047, 10'd0);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd2047, 10'd1023);
      send_request(brbps_pkg::OP_WRITE, 8'h00, 11'd2047, 10'd1023);
      send_request(brbps_pkg::OP_WRITE, 8'hFF, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_WRITE, 8'h5A, 11'd1024, 10'd512);
      send_request(brbps_pkg::OP_PEEK, 8'hFF, 11'd2047, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd2);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd3);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1023);
      send_request(brbps_pkg::OP_SKIP, 8'hFF, 11'd0, 10'd1023);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd1, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_WRITE, 8'hA5, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd2047, 10'd0);
      send_request(brbps_pkg::OP_QUERY, 8'h00, 11'd0, 10'd0);
   endtask

   // Capacity zero, one, saturated and small with wrapping positions
   task automatic test_capacity_extremes();
      send_idle_pct = 10;
      recv_idle_pct = 10;
      // zero counts as one slot
      write_capacity(32'd0);
      send_request(brbps_pkg::OP_WRITE, 8'h11, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_WRITE, 8'h22, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd5, 10'd0);
      write_capacity(32'd1);
      repeat (3) begin
         send_request(brbps_pkg::OP_WRITE, BYTE_W'($urandom), 11'd0, 10'd0);
         send_request(brbps_pkg::OP_WRITE, BYTE_W'($urandom), 11'd0, 10'd0);
         send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);
         send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd1, 10'd0);
      end
      // above the storage size: saturate, then fill to the brim
      write_capacity(32'd2047);
      for (int i = 0; i < DEPTH; i++) begin
         send_request(brbps_pkg::OP_WRITE, BYTE_W'($urandom), AMT_W'($urandom),
                      OFS_W'($urandom));
      end
      send_request(brbps_pkg::OP_WRITE, 8'hEE, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1023);
      send_request(brbps_pkg::OP_QUERY, 8'h00, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd1023, 10'd0);
      send_request(brbps_pkg::OP_WRITE, 8'h3C, 11'd0, 10'd0);
      send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1);
      send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd2047, 10'd0);
      // small ring, positions wrap, offsets past the capacity
      write_capacity({21'h1FFFFF, 11'd3});
      repeat (4) begin
         send_request(brbps_pkg::OP_WRITE, BYTE_W'($urandom), 11'd0, 10'd0);
         send_request(brbps_pkg::OP_WRITE, BYTE_W'($urandom), 11'd0, 10'd0);
         send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1);
         send_request(brbps_pkg::OP_PEEK, 8'h00, 11'd0, 10'd4);
         send_request(brbps_pkg::OP_SKIP, 8'h00, 11'd1, 10'd0);
      end
      write_capacity(32'd1024);
   endtask

   // Long result stall while requests keep coming, then a full drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_capacity(32'd16);
      hold_requests++;
      send_random(30);
      drain_results();
      send_random(10);
      drain_results();
   endtask

   // Random requests in runs, each run on a fresh capacity
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      int sel;
      int cap;
      int done;
      int run;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      done = 0;
      while (done < count) begin
         sel = $urandom_range(9);
         if (sel < 4) cap = $urandom_range(1, 8);
         else if (sel < 6) cap = $urandom_range(9, 64);
         else if (sel < 8) cap = $urandom_range(65, 1024);
         else if (sel == 8) cap = 0;
         else cap = $urandom_range(1025, 2047);
         write_capacity({21'($urandom), 11'(cap)});
         run = $urandom_range(8, 20);
         send_random(run);
         done += run;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = brbps_pkg::OP_QUERY;
      req_data_byte = '0;
      req_amount    = '0;
      req_offset    = '0;
      rsp_ready     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      shadow_capacity = brbps_pkg::CAP_RESET;
      shadow_rd_pos = 0;
      shadow_wr_pos = 0;
      shadow_fill   = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_capacity_extremes();
      test_backpressure();
      test_random_traffic(35, 80, 30);
      test_random_traffic(80, 35, 30);
      test_random_traffic(0, 0, 30);

      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
